@@ sv/vmm_pkg.sv @@
`timescale 1ns / 1ps

package vmm_pkg;

	localparam int ONE_Q14        = 16384;
	localparam int STEER_DEADBAND = 819;
	localparam int PIVOT_LIMIT    = 1638;
	localparam int OUT_SCALE      = 1000;
	localparam int YAW_AUTH       = 200;
	localparam int GAIN_MIN       = 1638;
	localparam int GAIN_MAX       = 32768;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_EXPO = 2'd1;
	localparam logic [1:0] REG_GAIN = 2'd2;

	typedef enum logic [1:0] {
		MODE_CAR   = 2'd0,
		MODE_BOAT  = 2'd1,
		MODE_PLANE = 2'd2,
		MODE_QUAD  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [14:0] expo;
		logic [15:0] gain;
	} cfg_t;

	// Load enables of the seven pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} pipe_ld_t;

endpackage

@@ sv/vehicle_motor_mixer_with_expo.sv @@
`timescale 1ns / 1ps

// Four-channel motor and servo mixer with an expo curve. Each request carries
// throttle, steering, pitch and roll sticks in Q1.14; each stick is saturated
// to +-1.0, shaped by the expo curve and then mixed for the vehicle mode set
// over the configuration port (skid-steer car, two-motor boat, plane or X
// quadcopter) into four channel values scaled to +-1000. The block is a
// seven-stage pipeline: it takes one request every clock cycle while the
// output side is not stalled, and results leave in the order accepted. Every
// stage has its own valid bit and holds its request when the stage after it
// is full and cannot load, so a stall on the output fills the bubbles first
// and only then lowers s_tready. Configuration should be written while no
// request is in flight.
module vehicle_motor_mixer_with_expo (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// throttle_cmd [15:0], steer_cmd [31:16], pitch_cmd [47:32], roll_cmd [63:48]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_ch0 [10:0], out_ch1 [21:11], out_ch2 [32:22], out_ch3 [43:33], zero [47:44]
	output logic [47:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vmm_pkg::*;

	cfg_t               cfg;
	pipe_ld_t           ld;
	logic [7:1]         vld_q;
	logic signed [15:0] cmd [4];
	logic signed [15:0] crv [4];
	logic signed [15:0] mv [4];
	logic [9:0]         mq [4];
	logic               mquad;
	logic signed [10:0] ch [4];

	vmm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A stage may load when it is empty or when the stage after it loads.
	always_comb begin
		ld.s7 = !vld_q[7] || m_tready;
		ld.s6 = !vld_q[6] || ld.s7;
		ld.s5 = !vld_q[5] || ld.s6;
		ld.s4 = !vld_q[4] || ld.s5;
		ld.s3 = !vld_q[3] || ld.s4;
		ld.s2 = !vld_q[2] || ld.s3;
		ld.s1 = !vld_q[1] || ld.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld.s1) vld_q[1] <= s_tvalid;
			if (ld.s2) vld_q[2] <= vld_q[1];
			if (ld.s3) vld_q[3] <= vld_q[2];
			if (ld.s4) vld_q[4] <= vld_q[3];
			if (ld.s5) vld_q[5] <= vld_q[4];
			if (ld.s6) vld_q[6] <= vld_q[5];
			if (ld.s7) vld_q[7] <= vld_q[6];
		end
	end

	assign s_tready = ld.s1;
	assign m_tvalid = vld_q[7];

	assign cmd[0] = s_tdata[15:0];
	assign cmd[1] = s_tdata[31:16];
	assign cmd[2] = s_tdata[47:32];
	assign cmd[3] = s_tdata[63:48];

	for (genvar g = 0; g < 4; g++) begin : g_expo
		vmm_expo u_expo (
			.clk  (clk),
			.ld   (ld),
			.expo (cfg.expo),
			.x    (cmd[g]),
			.y_s4 (crv[g])
		);
	end

	vmm_mix u_mix (
		.clk     (clk),
		.ld      (ld),
		.cfg     (cfg),
		.t       (crv[0]),
		.s       (crv[1]),
		.p       (crv[2]),
		.r       (crv[3]),
		.v_s6    (mv),
		.q_s6    (mq),
		.quad_s6 (mquad)
	);

	vmm_scale u_scale (
		.clk   (clk),
		.ld    (ld),
		.v     (mv),
		.q     (mq),
		.quad  (mquad),
		.ch_s7 (ch)
	);

	assign m_tdata = {4'd0, ch[3], ch[2], ch[1], ch[0]};

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_q == 7'h7f && !m_tready))
		else $error("input side stalled while the pipeline has a free stage");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[4] && !ld.s5) |=> vld_q[4])
		else $error("a stalled request left the middle of the pipeline");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ch[0] >= -11'sd1000 && ch[0] <= 11'sd1000 &&
			ch[1] >= -11'sd1000 && ch[1] <= 11'sd1000 &&
			ch[2] >= -11'sd1000 && ch[2] <= 11'sd1000 &&
			ch[3] >= -11'sd1000 && ch[3] <= 11'sd1000))
		else $error("channel value outside full scale");

	a_cfg_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_q[1]) |-> (cfg.expo <= 15'(ONE_Q14) &&
			cfg.gain >= 16'(GAIN_MIN) && cfg.gain <= 16'(GAIN_MAX)))
		else $error("configuration register out of range");

endmodule

@@ sv/vmm_cfg.sv @@
`timescale 1ns / 1ps

module vmm_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output vmm_pkg::cfg_t      cfg
);
	import vmm_pkg::*;

	mode_t       mode_q;
	logic [14:0] expo_q;
	logic [15:0] gain_q;
	logic        wr;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CAR;
			expo_q <= '0;
			gain_q <= 16'(ONE_Q14);
		end else if (wr) begin
			unique case (idx)
				REG_MODE: mode_q <= mode_t'(pwdata[1:0]);
				REG_EXPO: begin
					if (pwdata[14:0] > 15'(ONE_Q14))
						expo_q <= 15'(ONE_Q14);
					else
						expo_q <= pwdata[14:0];
				end
				REG_GAIN: begin
					if (pwdata[15:0] < 16'(GAIN_MIN))
						gain_q <= 16'(GAIN_MIN);
					else if (pwdata[15:0] > 16'(GAIN_MAX))
						gain_q <= 16'(GAIN_MAX);
					else
						gain_q <= pwdata[15:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE: prdata = {30'd0, mode_q};
			REG_EXPO: prdata = {17'd0, expo_q};
			REG_GAIN: prdata = {16'd0, gain_q};
			default:  prdata = '0;
		endcase
	end

	assign cfg = '{mode: mode_q, expo: expo_q, gain: gain_q};

endmodule

@@ sv/vmm_expo.sv @@
`timescale 1ns / 1ps

module vmm_expo (
	input  logic                clk,
	input  vmm_pkg::pipe_ld_t   ld,
	input  logic [14:0]         expo,
	input  logic signed [15:0]  x,
	output logic signed [15:0]  y_s4
);
	import vmm_pkg::*;

	logic signed [15:0] xc;
	logic [14:0]        a_c;
	logic [43:0]        cube_full;
	logic [29:0]        sum;

	logic               neg_s1, neg_s2, neg_s3;
	logic [14:0]        a_s1, a_s2;
	logic [28:0]        sq_s1;
	logic [14:0]        cub_s2;
	logic [28:0]        pc_s3, pl_s3;

	always_comb begin
		if (x > 16'sd16384)
			xc = 16'sd16384;
		else if (x < -16'sd16384)
			xc = -16'sd16384;
		else
			xc = x;
		a_c = xc[15] ? 15'(-xc) : xc[14:0];
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			neg_s1 <= xc[15];
			a_s1   <= a_c;
			sq_s1  <= 29'(a_c) * 29'(a_c);
		end
	end

	// The cube is a^3 scaled back to unsigned Q1.14, truncated.
	assign cube_full = 44'(sq_s1) * 44'(a_s1);

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			neg_s2 <= neg_s1;
			a_s2   <= a_s1;
			cub_s2 <= cube_full[42:28];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			neg_s3 <= neg_s2;
			pc_s3  <= 29'(cub_s2) * 29'(expo);
			pl_s3  <= 29'(a_s2) * 29'(15'(ONE_Q14) - expo);
		end
	end

	assign sum = 30'(pc_s3) + 30'(pl_s3);

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			if (neg_s3)
				y_s4 <= -$signed({1'b0, sum[28:14]});
			else
				y_s4 <= $signed({1'b0, sum[28:14]});
		end
	end

endmodule

@@ sv/vmm_mix.sv @@
`timescale 1ns / 1ps

module vmm_mix (
	input  logic                clk,
	input  vmm_pkg::pipe_ld_t   ld,
	input  vmm_pkg::cfg_t       cfg,
	input  logic signed [15:0]  t,
	input  logic signed [15:0]  s,
	input  logic signed [15:0]  p,
	input  logic signed [15:0]  r,
	output logic signed [15:0]  v_s6 [4],
	output logic [9:0]          q_s6 [4],
	output logic                quad_s6
);
	import vmm_pkg::*;

	function automatic logic signed [15:0] sat_q14(input logic signed [17:0] d);
		if (d > 18'sd16384)
			return 16'sd16384;
		else if (d < -18'sd16384)
			return -16'sd16384;
		else
			return 16'(d);
	endfunction

	logic [14:0]        abs_t, abs_s, base;
	logic [30:0]        k_full;
	logic signed [17:0] pe, re, se;
	logic signed [17:0] dsum [4];

	logic signed [15:0] t_s5, s_s5, p_s5, r_s5;
	logic [16:0]        k_s5;
	logic               dead_s5, pivot_s5, spos_s5;
	logic signed [26:0] n_s5 [4];

	logic signed [17:0] te, ke, lft, rgt;
	logic signed [15:0] lc, rc;
	logic signed [15:0] v_c [4];
	logic [9:0]         q_c [4];

	always_comb begin
		abs_t  = t[15] ? 15'(-t) : t[14:0];
		abs_s  = s[15] ? 15'(-s) : s[14:0];
		base   = t[15] ? 15'd0 : t[14:0];
		k_full = 31'(abs_s) * 31'(cfg.gain);
		pe     = 18'(p);
		re     = 18'(r);
		se     = 18'(s);
		// X-frame signs: front left, front right, rear left, rear right.
		dsum[0] = -pe + re - se;
		dsum[1] = -pe - re + se;
		dsum[2] =  pe + re + se;
		dsum[3] =  pe - re - se;
	end

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			t_s5     <= t;
			s_s5     <= s;
			p_s5     <= p;
			r_s5     <= r;
			k_s5     <= k_full[30:14];
			dead_s5  <= abs_s > 15'(STEER_DEADBAND);
			pivot_s5 <= abs_t <= 15'(PIVOT_LIMIT);
			spos_s5  <= !s[15];
			for (int i = 0; i < 4; i++)
				n_s5[i] <= $signed({12'd0, base}) * 27'sd1000 + 27'(dsum[i]) * 27'sd200;
		end
	end

	always_comb begin
		te  = 18'(t_s5);
		ke  = $signed({1'b0, k_s5});
		lft = te;
		rgt = te;
		if (dead_s5) begin
			if (spos_s5) begin
				if (pivot_s5) begin
					lft = ke;
					rgt = -ke;
				end else begin
					rgt = te - ke;
					if (te > 0 && rgt < 0) rgt = '0;
					if (te < 0 && rgt > 0) rgt = '0;
				end
			end else begin
				if (pivot_s5) begin
					lft = -ke;
					rgt = ke;
				end else begin
					lft = te - ke;
					if (te > 0 && lft < 0) lft = '0;
					if (te < 0 && lft > 0) lft = '0;
				end
			end
		end
		lc = sat_q14(lft);
		rc = sat_q14(rgt);

		for (int i = 0; i < 4; i++) begin
			if (n_s5[i][26])
				q_c[i] = '0;
			else if (n_s5[i] > 27'sd16384000)
				q_c[i] = 10'(OUT_SCALE);
			else
				q_c[i] = n_s5[i][23:14];
		end

		unique case (cfg.mode)
			MODE_CAR: begin
				v_c[0] = lc;
				v_c[1] = lc;
				v_c[2] = rc;
				v_c[3] = rc;
			end
			MODE_BOAT: begin
				v_c[0] = lc;
				v_c[1] = rc;
				v_c[2] = '0;
				v_c[3] = '0;
			end
			MODE_PLANE: begin
				v_c[0] = t_s5[15] ? 16'sd0 : t_s5;
				v_c[1] = r_s5;
				v_c[2] = p_s5;
				v_c[3] = s_s5;
			end
			MODE_QUAD: begin
				v_c[0] = '0;
				v_c[1] = '0;
				v_c[2] = '0;
				v_c[3] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			v_s6    <= v_c;
			q_s6    <= q_c;
			quad_s6 <= cfg.mode == MODE_QUAD;
		end
	end

endmodule

@@ sv/vmm_scale.sv @@
`timescale 1ns / 1ps

module vmm_scale (
	input  logic                clk,
	input  vmm_pkg::pipe_ld_t   ld,
	input  logic signed [15:0]  v [4],
	input  logic [9:0]          q [4],
	input  logic                quad,
	output logic signed [10:0]  ch_s7 [4]
);
	import vmm_pkg::*;

	logic [14:0] mag [4];
	logic [24:0] prod [4];

	// Scaling works on the magnitude so that the result truncates toward zero.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i]  = v[i][15] ? 15'(-v[i]) : v[i][14:0];
			prod[i] = 25'(mag[i]) * 25'(OUT_SCALE);
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s7) begin
			for (int i = 0; i < 4; i++) begin
				if (quad)
					ch_s7[i] <= $signed({1'b0, q[i]});
				else if (v[i][15])
					ch_s7[i] <= -$signed({1'b0, prod[i][23:14]});
				else
					ch_s7[i] <= $signed({1'b0, prod[i][23:14]});
			end
		end
	end

endmodule

@@ dv/vehicle_motor_mixer_with_expo_test.sv @@
`timescale 1ns / 1ps

// Keeps a copy of the three mixer settings and the queue of channel values
// that accepted requests are due to produce.
class mixer_scoreboard;
	typedef logic [3:0][10:0] channels_t;

	vmm_pkg::mode_t mode = vmm_pkg::MODE_CAR;
	int expo_weight = 0;
	int steer_gain = vmm_pkg::ONE_Q14;
	channels_t expected_channels[$];
	int failures = 0;

	static function int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function void set_register(logic [1:0] idx, logic [31:0] value);
		case (idx)
			vmm_pkg::REG_MODE: mode = vmm_pkg::mode_t'(value[1:0]);
			vmm_pkg::REG_EXPO:
				expo_weight = (value[14:0] > 15'd16384) ? vmm_pkg::ONE_Q14 : int'(value[14:0]);
			vmm_pkg::REG_GAIN:
				steer_gain = clamp(int'(value[15:0]), vmm_pkg::GAIN_MIN, vmm_pkg::GAIN_MAX);
			default: ;
		endcase
	endfunction

	function void check_readback(logic [1:0] idx, logic [31:0] actual);
		logic [31:0] want;
		case (idx)
			vmm_pkg::REG_MODE: want = 32'(mode);
			vmm_pkg::REG_EXPO: want = 32'(expo_weight);
			vmm_pkg::REG_GAIN: want = 32'(steer_gain);
			default: return;
		endcase
		if (actual !== want) begin
			$display("%0t register %0d read back: expected %0d, actual %0d",
				$time, idx, want, actual);
			failures++;
		end
	endfunction

	// Odd expo curve: weighted blend of the cube and the linear value.
	function int curve(int x);
		longint a, c, y;
		if (expo_weight == 0)
			return x;
		a = (x < 0) ? -x : x;
		c = (a * a * a) >> 28;
		y = (c * expo_weight + a * (vmm_pkg::ONE_Q14 - expo_weight)) >> 14;
		return (x < 0) ? -int'(y) : int'(y);
	endfunction

	static function logic [10:0] to_channel(int v);
		int c;
		c = clamp(v, -vmm_pkg::ONE_Q14, vmm_pkg::ONE_Q14);
		return 11'((c * vmm_pkg::OUT_SCALE) / vmm_pkg::ONE_Q14);
	endfunction

	function void steer_sides(int t, int s, output int left, output int right);
		int as, at, k;
		left = t;
		right = t;
		as = (s < 0) ? -s : s;
		at = (t < 0) ? -t : t;
		if (as > vmm_pkg::STEER_DEADBAND) begin
			k = (as * steer_gain) >> 14;
			if (at <= vmm_pkg::PIVOT_LIMIT) begin
				left = (s > 0) ? k : -k;
				right = -left;
			end else if (s > 0) begin
				// The inner side may slow to a stop but never reverses.
				right = t - k;
				if ((t > 0 && right < 0) || (t < 0 && right > 0))
					right = 0;
			end else begin
				left = t - k;
				if ((t > 0 && left < 0) || (t < 0 && left > 0))
					left = 0;
			end
		end
	endfunction

	static function logic [10:0] motor(int base, int dp, int dr, int dy);
		longint n;
		n = longint'(base) * vmm_pkg::OUT_SCALE + longint'(vmm_pkg::YAW_AUTH) * (dp + dr + dy);
		if (n < 0)
			n = 0;
		if (n > longint'(vmm_pkg::OUT_SCALE) * vmm_pkg::ONE_Q14)
			n = longint'(vmm_pkg::OUT_SCALE) * vmm_pkg::ONE_Q14;
		return 11'(n / vmm_pkg::ONE_Q14);
	endfunction

	function void note_command(logic [63:0] cmd);
		int t, s, p, r, left, right, base;
		channels_t ch;
		t = curve(clamp(int'($signed(cmd[15:0])), -vmm_pkg::ONE_Q14, vmm_pkg::ONE_Q14));
		s = curve(clamp(int'($signed(cmd[31:16])), -vmm_pkg::ONE_Q14, vmm_pkg::ONE_Q14));
		p = curve(clamp(int'($signed(cmd[47:32])), -vmm_pkg::ONE_Q14, vmm_pkg::ONE_Q14));
		r = curve(clamp(int'($signed(cmd[63:48])), -vmm_pkg::ONE_Q14, vmm_pkg::ONE_Q14));
		case (mode)
			vmm_pkg::MODE_CAR: begin
				steer_sides(t, s, left, right);
				ch[0] = to_channel(left);
				ch[1] = ch[0];
				ch[2] = to_channel(right);
				ch[3] = ch[2];
			end
			vmm_pkg::MODE_BOAT: begin
				steer_sides(t, s, left, right);
				ch[0] = to_channel(left);
				ch[1] = to_channel(right);
				ch[2] = '0;
				ch[3] = '0;
			end
			vmm_pkg::MODE_PLANE: begin
				ch[0] = to_channel(clamp(t, 0, vmm_pkg::ONE_Q14));
				ch[1] = to_channel(r);
				ch[2] = to_channel(p);
				ch[3] = to_channel(s);
			end
			default: begin
				base = clamp(t, 0, vmm_pkg::ONE_Q14);
				ch[0] = motor(base, -p, r, -s);
				ch[1] = motor(base, -p, -r, s);
				ch[2] = motor(base, p, r, s);
				ch[3] = motor(base, p, -r, -s);
			end
		endcase
		expected_channels.push_back(ch);
	endfunction

	function void check_result(logic [47:0] beat);
		channels_t want;
		if (expected_channels.size() == 0) begin
			$display("%0t result with nothing outstanding: expected none, actual %h",
				$time, beat);
			failures++;
			return;
		end
		want = expected_channels.pop_front();
		for (int i = 0; i < 4; i++) begin
			if (beat[11*i +: 11] !== want[i]) begin
				$display("%0t channel %0d: expected %0d, actual %0d", $time, i,
					$signed(want[i]), $signed(beat[11*i +: 11]));
				failures++;
			end
		end
		if (beat[47:44] !== 4'd0) begin
			$display("%0t padding bits: expected 0, actual %h", $time, beat[47:44]);
			failures++;
		end
	endfunction

	function int pending();
		return expected_channels.size();
	endfunction
endclass

module vehicle_motor_mixer_with_expo_test;
	import vmm_pkg::*;

	// Index past the end of the register map; writes to it must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES = 32;
	localparam int PHASES = 12;
	localparam int REQUESTS_PER_PHASE = 152;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mixer_scoreboard board;
	int source_idle_pct = 23;
	int sink_idle_pct = 70;
	logic hold_off_go = 1'b0;

	// Sticks as throttle, steer, pitch, roll.
	int directed_sticks [6][4] = '{
		'{0, 0, 0, 0},
		'{16384, 16384, -16384, 16384},
		'{-32768, 32767, 32767, -32768},
		'{1638, 820, 819, -819},
		'{1639, -820, 5000, -5000},
		'{4000, 10000, -8000, 3000}
	};
	int knees [8] = '{0, 1, 819, 820, 1638, 1639, 16384, 16385};

	vehicle_motor_mixer_with_expo uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] random_stick();
		int v;
		case ($urandom_range(9))
			0, 1: v = int'($urandom_range(65535));
			2, 3: v = knees[$urandom_range(7)];
			4: v = int'($urandom_range(1700));
			default: v = int'($urandom_range(32768)) - 16384;
		endcase
		if ($urandom_range(1))
			v = -v;
		return 16'(v);
	endfunction

	task automatic send_command(input logic [63:0] cmd);
		while ($urandom_range(99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cmd;
		do @(posedge clk); while (!s_tready);
		board.note_command(cmd);
	endtask

	task automatic access_register(input logic is_write, input logic [1:0] idx,
			input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (is_write)
			board.set_register(idx, value);
		else
			board.check_readback(idx, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// The bus returns to idle between accesses.
		@(posedge clk);
	endtask

	// Stops offering requests and waits until every result has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending() > 0)
			@(posedge clk);
	endtask

	initial begin : result_sink
		int hold_off_left;
		hold_off_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (hold_off_go) begin
				hold_off_go = 1'b0;
				hold_off_left = HOLD_OFF_CYCLES;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] mode_word, expo_word, gain_word;
		board = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		access_register(1'b0, REG_MODE, '0);
		access_register(1'b0, REG_EXPO, '0);
		access_register(1'b0, REG_GAIN, '0);

		for (int m = 0; m < 4; m++) begin
			if (m != 0)
				access_register(1'b1, REG_MODE, 32'(m));
			foreach (directed_sticks[i])
				send_command({16'(directed_sticks[i][3]), 16'(directed_sticks[i][2]),
					16'(directed_sticks[i][1]), 16'(directed_sticks[i][0])});
			settle();
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			source_idle_pct = (phase < 4) ? 23 : ((phase < 8) ? 70 : 0);
			sink_idle_pct = (phase < 4) ? 70 : ((phase < 8) ? 23 : 0);

			mode_word = 32'((phase + phase / 4) % 4);
			case (phase)
				0: begin expo_word = 0;     gain_word = GAIN_MIN; end
				1: begin expo_word = 16384; gain_word = GAIN_MAX; end
				2: begin expo_word = 32767; gain_word = 0;        end
				3: begin expo_word = 1;     gain_word = 65535;    end
				4: begin expo_word = 16383; gain_word = 1637;     end
				5: begin expo_word = 16385; gain_word = 32769;    end
				6: begin expo_word = 0;     gain_word = ONE_Q14;  end
				default: begin
					expo_word = $urandom_range(16384);
					gain_word = $urandom_range(GAIN_MAX, GAIN_MIN);
				end
			endcase
			// Bits above each register's width must have no effect.
			if (phase % 2) begin
				mode_word |= $urandom & 32'hFFFF_FFFC;
				expo_word |= $urandom & 32'hFFFF_8000;
				gain_word |= $urandom & 32'hFFFF_0000;
			end
			access_register(1'b1, REG_MODE, mode_word);
			access_register(1'b1, REG_EXPO, expo_word);
			access_register(1'b1, REG_GAIN, gain_word);
			access_register(1'b1, REG_UNUSED, $urandom);
			access_register(1'b0, REG_MODE, '0);
			access_register(1'b0, REG_EXPO, '0);
			access_register(1'b0, REG_GAIN, '0);

			// With no idling on the input side the pipeline fills during the hold-off.
			if (phase == 8)
				hold_off_go = 1'b1;
			repeat (REQUESTS_PER_PHASE)
				send_command({random_stick(), random_stick(), random_stick(), random_stick()});
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ files.f @@
sv/vmm_pkg.sv
sv/vmm_cfg.sv
sv/vmm_expo.sv
sv/vmm_mix.sv
sv/vmm_scale.sv
sv/vehicle_motor_mixer_with_expo.sv
dv/vehicle_motor_mixer_with_expo_test.sv
